FILE: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 24;
    localparam logic [20:0] SAT_LIMIT = 21'd65280;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } out_item_t;

    // Edge flags of the window centre
    typedef struct packed {
        logic top;
        logic bot;
        logic lft;
        logic rgt;
    } edge_flags_t;

endpackage

FILE: rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read one address per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/sem_root.sv
// ----------------------------------------------------------------------------
// sem_root
// Sobel gradient and rounded square root for one colour channel,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module sem_root (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] tl,
    input  logic [7:0] tc,
    input  logic [7:0] tr,
    input  logic [7:0] ml,
    input  logic [7:0] mr,
    input  logic [7:0] bl,
    input  logic [7:0] bc,
    input  logic [7:0] br,
    output logic       done,
    output logic [7:0] result
);

    import sem_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQR  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic signed [11:0] gx_reg, gy_reg;
    logic [20:0]        s_reg;
    logic [7:0]         k_reg;
    logic [7:0]         bit_reg;
    logic signed [11:0] gx_c, gy_c;
    logic signed [23:0] gxx_c, gyy_c;
    logic [7:0]         t_c;
    logic [15:0]        tt_c;
    logic [16:0]        kk_c;

    // Gradients from the masked window
    always_comb
    begin
        gx_c = $signed({4'd0, tr}) - $signed({4'd0, tl})
             + $signed({3'd0, mr, 1'b0}) - $signed({3'd0, ml, 1'b0})
             + $signed({4'd0, br}) - $signed({4'd0, bl});
        gy_c = $signed({4'd0, bl}) + $signed({3'd0, bc, 1'b0}) + $signed({4'd0, br})
             - $signed({4'd0, tl}) - $signed({3'd0, tc, 1'b0}) - $signed({4'd0, tr});
        gxx_c = gx_reg * gx_reg;
        gyy_c = gy_reg * gy_reg;
        t_c  = k_reg | bit_reg;
        tt_c = t_c * t_c;
        kk_c = 17'(k_reg) * 17'(k_reg) + 17'(k_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_SQR;
            ST_SQR:  state_next = ST_ROOT;
            ST_ROOT: if (bit_reg[0]) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture gradients, square, then one root bit per cycle
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                gx_reg  <= gx_c;
                gy_reg  <= gy_c;
                k_reg   <= 8'd0;
                bit_reg <= 8'h80;
            end
            ST_SQR:
            begin
                s_reg <= gxx_c[20:0] + gyy_c[20:0];
            end
            ST_ROOT:
            begin
                if ({5'd0, tt_c} <= s_reg)
                begin
                    k_reg <= t_c;
                end
                bit_reg <= bit_reg >> 1;
            end
            ST_DONE:
            begin
                if (s_reg > SAT_LIMIT)
                begin
                    result <= 8'd255;
                end
                else if (s_reg > {4'd0, kk_c})
                begin
                    result <= k_reg + 8'd1;
                end
                else
                begin
                    result <= k_reg;
                end
            end
            default: ;
        endcase
    end

    assign done = (state_reg == ST_DONE);

endmodule

FILE: rtl/sobel_edge_magnitude_rgb_top.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top
// Streaming 3x3 Sobel magnitude on RGB pixels with two line-store RAMs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid / in_ready       | in_data  (in_item_t)
//  out     | output    | out_valid / out_ready     | out_data (out_item_t)
//  cfg     | input     | cfg_we (no wait)          | cfg_index, cfg_data
//
// One transaction at a time: line-store read, window update and write-back,
// the bit-serial root unit and the output load, in that order, from one
// accepted pixel item to the next when it gives a result. An item with no
// result returns to idle after the window update without starting the
// roots, and an ignored drain tick is taken in idle. Reset clears counters
// and window; line stores are not cleared. A stalled output holds its
// register; the next result waits in the output load until it is taken.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sem_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sem_pkg::out_item_t   out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int PW = CW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_WIN  = 3'd2;
    localparam logic [2:0] ST_CALC = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [11:0]  width_reg;
    logic [12:0]  height_reg;
    logic [CW-1:0] w_c;
    logic [RW-1:0] h_c;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [PW-1:0] pend_reg;
    logic [PIX_W-1:0] win_reg [9];
    in_item_t     item_reg;
    logic [PIX_W-1:0] bottom_reg;
    logic         use_top_reg, use_mid_reg, col_ok_reg, wr_up_reg;
    edge_flags_t  flags_reg;
    logic         last_reg;
    logic         emit_reg;
    out_item_t    out_reg;
    logic         out_valid_reg;
    logic [PIX_W-1:0] up_rdata, mid_rdata, top_c, mid_c;
    logic         accept, is_pix, ignore_c, restart_c, out_free;
    logic [RW-1:0] row_c;
    logic [CW-1:0] col_c;
    logic [AW-1:0] addr;
    logic         root_start;
    logic [2:0]   root_done;
    logic [7:0]   root_res [3];
    logic [7:0]   tap [9][3];

    // Effective frame size
    always_comb
    begin
        w_c = (width_reg == 12'd0) ? CW'(1)
            : ({20'd0, width_reg} > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_reg);
        h_c = (height_reg == 13'd0) ? RW'(1)
            : ({19'd0, height_reg} > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_reg);
    end

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_we;
    assign accept    = in_valid && in_ready;
    assign is_pix    = (in_data.opcode == OP_PIXEL);
    assign ignore_c  = !is_pix && (in_row_reg < h_c);
    assign restart_c = is_pix && (in_row_reg >= h_c);
    assign row_c     = restart_c ? '0 : in_row_reg;
    assign col_c     = restart_c ? '0 : in_col_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign addr      = in_col_reg[AW-1:0];

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk(clk),
        .we(state_reg == ST_WIN && item_reg.opcode == OP_PIXEL && wr_up_reg && col_ok_reg),
        .addr(addr), .wdata(mid_c), .rdata(up_rdata)
    );
    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk(clk), .we(state_reg == ST_WIN && item_reg.opcode == OP_PIXEL && col_ok_reg),
        .addr(addr), .wdata(bottom_reg), .rdata(mid_rdata)
    );

    // Masked line-store data
    assign top_c = (use_top_reg && col_ok_reg) ? up_rdata : '0;
    assign mid_c = (use_mid_reg && col_ok_reg) ? mid_rdata : '0;

    // Window taps split per channel; edge masking is applied at the root inputs
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                tap[i][ch] = win_reg[i][(2-ch)*8 +: 8];
            end
        end
    end

    // Start the roots once the window has advanced and a result is owed
    assign root_start = (state_reg == ST_CALC) && emit_reg;

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        sem_root u_root (
            .clk(clk), .rst_n(rst_n), .start(root_start),
            .tl((flags_reg.top && flags_reg.lft) ? tap[0][ch] : 8'd0),
            .tc(flags_reg.top ? tap[1][ch] : 8'd0),
            .tr((flags_reg.top && flags_reg.rgt) ? tap[2][ch] : 8'd0),
            .ml(flags_reg.lft ? tap[3][ch] : 8'd0),
            .mr(flags_reg.rgt ? tap[5][ch] : 8'd0),
            .bl((flags_reg.bot && flags_reg.lft) ? tap[6][ch] : 8'd0),
            .bc(flags_reg.bot ? tap[7][ch] : 8'd0),
            .br((flags_reg.bot && flags_reg.rgt) ? tap[8][ch] : 8'd0),
            .done(root_done[ch]), .result(root_res[ch])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && !ignore_c) state_next = ST_READ;
            ST_READ: state_next = ST_WIN;
            ST_WIN:  state_next = ST_CALC;
            ST_CALC:
            begin
                if (!emit_reg) state_next = ST_IDLE;
                else if (root_done[0]) state_next = ST_OUT;
            end
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 12'd640;
            height_reg    <= 13'd480;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            // Register write restarts the frame and drops owed results
            if (cfg_index == REG_FRAME_WIDTH) width_reg <= cfg_data[11:0];
            if (cfg_index == REG_FRAME_HEIGHT) height_reg <= cfg_data;
            if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                pend_reg    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && restart_c)
                    begin
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                        pend_reg    <= '0;
                    end
                end
                ST_WIN:
                begin
                    win_reg[0] <= win_reg[1];
                    win_reg[1] <= win_reg[2];
                    win_reg[2] <= top_c;
                    win_reg[3] <= win_reg[4];
                    win_reg[4] <= win_reg[5];
                    win_reg[5] <= mid_c;
                    win_reg[6] <= win_reg[7];
                    win_reg[7] <= win_reg[8];
                    win_reg[8] <= bottom_reg;
                    if (in_col_reg + CW'(1) >= w_c)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + RW'(1);
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + CW'(1);
                    end
                    if (pend_reg + PW'(1) <= PW'(w_c) + PW'(1))
                    begin
                        pend_reg <= pend_reg + PW'(1);
                    end
                    last_reg <= (out_row_reg + RW'(1) >= h_c) && (out_col_reg + CW'(1) >= w_c);
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (last_reg)
                        begin
                            in_col_reg  <= '0;
                            in_row_reg  <= '0;
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                            pend_reg    <= '0;
                        end
                        else if (out_col_reg + CW'(1) >= w_c)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + RW'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + CW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload capture for the transaction in flight, edge flags and the output load
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= in_data;
            bottom_reg  <= is_pix ? {in_data.red_in, in_data.green_in, in_data.blue_in} : '0;
            col_ok_reg  <= (col_c < CW'(MAX_WIDTH));
            use_top_reg <= (row_c >= RW'(2)) && (row_c - RW'(2) < h_c);
            use_mid_reg <= (row_c >= RW'(1)) && (row_c - RW'(1) < h_c);
            wr_up_reg   <= (row_c >= RW'(1));
        end
        if (state_reg == ST_WIN)
        begin
            emit_reg      <= (pend_reg > PW'(w_c));
            flags_reg.top <= (out_row_reg != '0);
            flags_reg.bot <= (out_row_reg + RW'(1) < h_c);
            flags_reg.lft <= (out_col_reg != '0);
            flags_reg.rgt <= (out_col_reg + CW'(1) < w_c);
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_reg.red_out    <= root_res[0];
            out_reg.green_out  <= root_res[1];
            out_reg.blue_out   <= root_res[2];
            out_reg.frame_last <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !cfg_we |=> out_valid && $stable(out_data))
        else $error("output not held under stall");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input ready while busy");
    a_roots_together: assert property (@(posedge clk) disable iff (!rst_n)
        root_done == 3'd0 || root_done == 3'd7)
        else $error("root units out of step");

endmodule
